@@ design/dctpp_pkg.sv @@
// Shared types, constants and the twiddle table for the DCT/DST row pre/post processor.
// No dependencies; imported by dctpp_front, dctpp_jobq, dctpp_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package dctpp_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int MAX_ROW    = 32;
  localparam int ADDR_W     = $clog2(MAX_ROW);
  localparam int LEN_W      = 6;
  localparam int MODE_W     = 3;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int TW_W       = 16;
  localparam int PROD_W     = (SAMPLE_W + 1) + (TW_W + 1);
  localparam int SUM_W      = PROD_W + 1;
  localparam int TW_ENTRIES = MAX_ROW * MAX_ROW;
  localparam int TW_IDX_W   = $clog2(TW_ENTRIES);

  localparam logic [CFG_IDX_W-1:0] REG_MODE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ROW_LEN = CFG_IDX_W'(1);

  localparam int MB_POST = 0;
  localparam int MB_DCT3 = 1;
  localparam int MB_DST  = 2;

  localparam logic [1:0] CLS_PRE_DCT2  = 2'b00;
  localparam logic [1:0] CLS_POST_DCT2 = 2'b01;
  localparam logic [1:0] CLS_PRE_DCT3  = 2'b10;
  localparam logic [1:0] CLS_POST_DCT3 = 2'b11;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [LEN_W-1:0]  len;
  } job_t;

  typedef struct packed {
    logic                en;
    logic [ADDR_W-1:0]   addr;
    logic [SAMPLE_W-1:0] re;
    logic [SAMPLE_W-1:0] im;
  } wr_t;

  typedef struct packed {
    logic              busy;
    logic [MODE_W-1:0] mode;
  } back_stat_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ADDR1,
    B_ADDR2,
    B_DATA2,
    B_MUL,
    B_SUM
  } back_state_t;

  typedef logic [TW_ENTRIES-1:0][2*TW_W-1:0] tw_rom_t;

  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint unsigned ONE_Q30 = 64'd1073741824;

  // restoring long division, evaluated at elaboration only
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q, r;
    int b;
    q = 0;
    r = 0;
    for (b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // cos/sin of pi*k/(2n) in Q15, entry (n-1)*MAX_ROW + k
  function automatic tw_rom_t tw_build();
    tw_rom_t rom;
    longint unsigned x, x2, t, p, d, hc, hs, sv, cq, sq;
    int nn, kk, i, oi;
    rom = '0;
    hc = 0;
    hs = 0;
    for (nn = 1; nn <= MAX_ROW; nn++) begin
      for (kk = 0; kk < MAX_ROW; kk++) begin
        x  = udiv(PI_Q30 * longint'(kk) + longint'(nn), 2 * longint'(nn));
        x2 = (x * x) >> 30;
        for (oi = 0; oi < 2; oi++) begin
          t = ONE_Q30;
          for (i = 7; i >= 1; i--) begin
            if (oi == 1) d = longint'(2 * i) * longint'(2 * i + 1);
            else         d = longint'(2 * i - 1) * longint'(2 * i);
            p = udiv((x2 * t) >> 30, d);
            t = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
          end
          if (oi == 1) hs = t;
          else         hc = t;
        end
        sv = (x * hs) >> 30;
        cq = (hc + 64'd16384) >> 15;
        sq = (sv + 64'd16384) >> 15;
        if (cq > 64'd32767) cq = 64'd32767;
        if (sq > 64'd32767) sq = 64'd32767;
        rom[(nn - 1) * MAX_ROW + kk] = {cq[TW_W-1:0], sq[TW_W-1:0]};
      end
    end
    return rom;
  endfunction

  localparam tw_rom_t TW_ROM = tw_build();

endpackage
`default_nettype wire

@@ design/dctpp_ram.sv @@
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module dctpp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ design/dctpp_front.sv @@
// Front end: configuration registers, sample loading and row completion.
// Depends on dctpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dctpp_front (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [dctpp_pkg::SAMPLE_W-1:0] real_in,
  input  wire logic signed [dctpp_pkg::SAMPLE_W-1:0] imag_in,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [dctpp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [dctpp_pkg::CFG_DATA_W-1:0]    cfg_data,
  output dctpp_pkg::wr_t                           wr,
  output logic                                     push,
  output dctpp_pkg::job_t                          push_job,
  input  wire logic                                q_full,
  input  wire dctpp_pkg::back_stat_t               bstat
);
  import dctpp_pkg::*;

  logic [MODE_W-1:0] mode;
  logic [LEN_W-1:0]  row_len;
  logic [ADDR_W-1:0] load_count;
  logic [ADDR_W-1:0] load_count_next;
  logic [LEN_W-1:0]  n_eff;
  logic              accept;
  logic              complete;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full || bstat.busy;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    if (row_len < LEN_W'(2)) begin
      n_eff = LEN_W'(2);
    end else if (row_len > LEN_W'(MAX_ROW)) begin
      n_eff = LEN_W'(MAX_ROW);
    end else begin
      n_eff = row_len;
    end
  end

  assign complete = (LEN_W'(load_count) + LEN_W'(1)) >= n_eff;

  always_comb begin
    load_count_next = load_count;
    if (accept) begin
      load_count_next = complete ? '0 : load_count + ADDR_W'(1);
    end
  end

  assign wr.en   = accept;
  assign wr.addr = load_count;
  assign wr.re   = real_in;
  assign wr.im   = imag_in;

  assign push          = accept && complete;
  assign push_job.mode = mode;
  assign push_job.len  = n_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= '0;
      row_len    <= LEN_W'(MAX_ROW);
      load_count <= '0;
    end else begin
      load_count <= load_count_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MODE:    mode    <= cfg_data[MODE_W-1:0];
          REG_ROW_LEN: row_len <= cfg_data[LEN_W-1:0];
          default:     ;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

@@ design/dctpp_jobq.sv @@
// One-entry row job queue between the front end and the back end.
// Depends on dctpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dctpp_jobq (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire dctpp_pkg::job_t push_job,
  output logic                 full,
  input  wire logic            pop,
  output dctpp_pkg::job_t      job
);
  import dctpp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (pop) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      job <= push_job;
    end
  end

endmodule
`default_nettype wire

@@ design/dctpp_back.sv @@
// Back end: row read sequencer, twiddle arithmetic and output register.
// Depends on dctpp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dctpp_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 job_valid,
  input  wire dctpp_pkg::job_t                      job,
  output logic                                      pop,
  output dctpp_pkg::back_stat_t                     bstat,
  output logic [dctpp_pkg::ADDR_W-1:0]              raddr,
  input  wire logic [dctpp_pkg::SAMPLE_W-1:0]       rd_re,
  input  wire logic [dctpp_pkg::SAMPLE_W-1:0]       rd_im,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dctpp_pkg::SAMPLE_W-1:0]     real_out,
  output logic signed [dctpp_pkg::SAMPLE_W-1:0]     imag_out,
  output logic                                      last_out
);
  import dctpp_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SUM_W-1:0] RND14 = SUM_W'(1) <<< 13;
  localparam logic signed [SUM_W-1:0] RND16 = SUM_W'(1) <<< 15;

  function automatic logic signed [SAMPLE_W-1:0] sat_w(input logic signed [SUM_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > SUM_W'(SMAX))      r = SMAX;
    else if (v < SUM_W'(SMIN)) r = SMIN;
    else                       r = v[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat_neg(input logic signed [SAMPLE_W-1:0] v);
    logic signed [SAMPLE_W-1:0] r;
    r = (v == SMIN) ? SMAX : -v;
    return r;
  endfunction

  back_state_t state, state_next;
  logic [MODE_W-1:0]  jmode;
  logic [LEN_W-1:0]   n;
  logic [ADDR_W-1:0]  j;
  logic               load_out;

  logic               post, dst_pre, dst_post;
  logic [1:0]         cls;
  logic [LEN_W-1:0]   jj, m, h, ub, mm, i1, i2, p1, p2, k;
  logic               conj, zero2, neg1, neg2;
  logic [TW_IDX_W-1:0] tw_idx;

  logic signed [SAMPLE_W-1:0] d1r, d1i, d2r;
  logic [TW_W-1:0]            tw_c, tw_s;
  logic signed [SAMPLE_W-1:0] u1, u2, pass_v;
  logic signed [SAMPLE_W:0]   u1e, u2e, w, op_b;
  logic signed [TW_W:0]       cs, ss;
  logic signed [PROD_W-1:0]   pa, pb, pc, pd;
  logic signed [SUM_W-1:0]    s_ab, s_cd;
  logic signed [SAMPLE_W-1:0] iv, core_re, core_im, fin_re;

  assign post     = jmode[MB_POST];
  assign dst_pre  = jmode[MB_DST] && !jmode[MB_POST];
  assign dst_post = jmode[MB_DST] && jmode[MB_POST];
  assign cls      = {jmode[MB_DCT3], jmode[MB_POST]};

  assign jj    = LEN_W'(j);
  assign m     = dst_post ? n - LEN_W'(1) - jj : jj;
  assign h     = n >> 1;
  assign ub    = ((n - LEN_W'(1)) >> 1) + LEN_W'(1);
  assign conj  = m > h;
  assign mm    = conj ? n - m : m;
  assign zero2 = (mm == '0);

  always_comb begin
    i1 = m;
    i2 = '0;
    k  = m;
    unique case (cls)
      CLS_PRE_DCT2: begin
        i1 = (m < ub) ? (m << 1) : n - ((m - ub) << 1) - LEN_W'(1) - LEN_W'(n[0]);
      end
      CLS_POST_DCT2: begin
        i1 = mm;
      end
      CLS_PRE_DCT3: begin
        i1 = mm;
        i2 = n - mm;
        k  = mm;
      end
      CLS_POST_DCT3: begin
        i1 = m[0] ? n - LEN_W'(1) - (m >> 1) : (m >> 1);
      end
      default: ;
    endcase
  end

  assign p1   = dst_pre ? n - LEN_W'(1) - i1 : i1;
  assign p2   = dst_pre ? n - LEN_W'(1) - i2 : i2;
  assign neg1 = dst_pre && i1[0];
  assign neg2 = dst_pre && i2[0];

  assign raddr  = (state == B_ADDR1) ? p1[ADDR_W-1:0] : p2[ADDR_W-1:0];
  assign tw_idx = TW_IDX_W'(n - LEN_W'(1)) * TW_IDX_W'(MAX_ROW) + TW_IDX_W'(k);

  // operand selection for the multiply stage
  assign u1     = neg1 ? sat_neg(d1r) : d1r;
  assign u2     = zero2 ? '0 : (neg2 ? sat_neg(d2r) : d2r);
  assign u1e    = (SAMPLE_W+1)'(u1);
  assign u2e    = (SAMPLE_W+1)'(u2);
  assign w      = conj ? -((SAMPLE_W+1)'(d1i)) : (SAMPLE_W+1)'(d1i);
  assign op_b   = post ? w : u2e;
  assign cs     = signed'({1'b0, tw_c});
  assign ss     = signed'({1'b0, tw_s});

  // round, saturate and negate stage
  assign s_ab = SUM_W'(pa) + SUM_W'(pb);
  assign s_cd = SUM_W'(pc) - SUM_W'(pd);

  always_comb begin
    core_re = pass_v;
    core_im = '0;
    iv      = sat_w((s_cd + RND16) >>> 16);
    case (cls)
      CLS_POST_DCT2: core_re = sat_w((s_ab + RND14) >>> 14);
      CLS_PRE_DCT3: begin
        core_re = sat_w((s_ab + RND16) >>> 16);
        core_im = conj ? sat_neg(iv) : iv;
      end
      default: ;
    endcase
    fin_re = (dst_post && j[0]) ? sat_neg(core_re) : core_re;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (job_valid) begin
          pop        = 1'b1;
          state_next = B_ADDR1;
        end
      end
      B_ADDR1: state_next = B_ADDR2;
      B_ADDR2: state_next = B_DATA2;
      B_DATA2: state_next = B_MUL;
      B_MUL:   state_next = B_SUM;
      B_SUM: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = (jj == n - LEN_W'(1)) ? B_IDLE : B_ADDR1;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      jmode <= job.mode;
      n     <= job.len;
      j     <= '0;
    end else if (load_out) begin
      j <= j + ADDR_W'(1);
    end
    if (state == B_ADDR2) begin
      d1r  <= rd_re;
      d1i  <= rd_im;
      tw_c <= TW_ROM[tw_idx][2*TW_W-1:TW_W];
      tw_s <= TW_ROM[tw_idx][TW_W-1:0];
    end
    if (state == B_DATA2) begin
      d2r <= rd_re;
    end
    if (state == B_MUL) begin
      pa     <= u1e * cs;
      pb     <= op_b * ss;
      pc     <= u1e * ss;
      pd     <= u2e * cs;
      pass_v <= u1;
    end
    if (load_out) begin
      real_out <= fin_re;
      imag_out <= core_im;
      last_out <= (jj == n - LEN_W'(1));
    end
  end

  assign bstat.busy = (state != B_IDLE);
  assign bstat.mode = jmode;

endmodule
`default_nettype wire

@@ design/dct_dst_fft_row_pre_post_processor_top.sv @@
// Top level of the DCT/DST row pre/post processor for FFT-based transforms.
// Depends on dctpp_pkg, dctpp_ram, dctpp_front, dctpp_jobq and dctpp_back.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------
//   in      | in_valid / in_stall  | real_in, imag_in
//   out     | out_valid / out_stall| real_out, imag_out, last_out
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A row of N samples loads at one sample per cycle unless in_stall holds it; the last
// sample queues a row job. The back end emits one result at a time via states B_ADDR1,
// B_ADDR2, B_DATA2, B_MUL and B_SUM (two reads of the single-read-port sample store,
// then multiply and round stages). Input stalls while a row job is queued or being
// emitted; the output register lets the next row load while the final result waits.
// Reset (rst, synchronous) sets mode 0, row length 32 and clears the load count.
`timescale 1ns / 1ps
`default_nettype none
module dct_dst_fft_row_pre_post_processor_top (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic signed [dctpp_pkg::SAMPLE_W-1:0] real_in,
  input  wire logic signed [dctpp_pkg::SAMPLE_W-1:0] imag_in,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic signed [dctpp_pkg::SAMPLE_W-1:0]     real_out,
  output logic signed [dctpp_pkg::SAMPLE_W-1:0]     imag_out,
  output logic                                      last_out,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [dctpp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [dctpp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import dctpp_pkg::*;

  wr_t               wr;
  logic              push;
  job_t              push_job;
  logic              q_full;
  logic              pop;
  job_t              qjob;
  back_stat_t        bstat;
  logic [ADDR_W-1:0] raddr;
  logic [SAMPLE_W-1:0] rd_re, rd_im;

  dctpp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .real_in   (real_in),
    .imag_in   (imag_in),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wr        (wr),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full),
    .bstat     (bstat)
  );

  dctpp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW)) u_ram_re (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.re),
    .raddr (raddr),
    .rdata (rd_re)
  );

  dctpp_ram #(.WIDTH(SAMPLE_W), .DEPTH(MAX_ROW)) u_ram_im (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.im),
    .raddr (raddr),
    .rdata (rd_im)
  );

  dctpp_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .job      (qjob)
  );

  dctpp_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (q_full),
    .job       (qjob),
    .pop       (pop),
    .bstat     (bstat),
    .raddr     (raddr),
    .rd_re     (rd_re),
    .rd_im     (rd_im),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .real_out  (real_out),
    .imag_out  (imag_out),
    .last_out  (last_out)
  );

  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_push_free: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("row job pushed into a full queue");

  a_pop_takes: assert property (@(posedge clk) disable iff (rst)
    pop |=> bstat.busy && bstat.mode == $past(qjob.mode))
    else $error("back end did not take the queued row job");

endmodule
`default_nettype wire
